// ===== hdl/lgrs_pkg.sv =====
// lgrs_pkg: shared constants and types for the row-streamed Life generation block
// used by lgrs_cell, lgrs_fifo and life_generation_row_stream_top; no dependencies
`timescale 1ns / 1ps

package lgrs_pkg;

  // row geometry: the row field is fixed at 64 bits, the grid may use fewer columns
  localparam int ROW_W       = 64;
  localparam int MAX_COLUMNS = 64;

  // column count register
  localparam int COL_W = 7;
  localparam logic [COL_W-1:0] COLS_RESET = COL_W'(40);

  // neighbourhood count, 0 to 9
  localparam int CNT_W = 4;
  localparam logic [CNT_W-1:0] BORN_COUNT = CNT_W'(3);
  localparam logic [CNT_W-1:0] KEEP_COUNT = CNT_W'(4);

  // result queue
  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int FCNT_W     = $clog2(FIFO_DEPTH + 1);

  // per-column live counts handed between neighbouring cells
  typedef struct packed {
    logic [1:0] a;  // above + pending + incoming row
    logic [1:0] b;  // row above the incoming row + incoming row
  } col_sum_t;

  localparam col_sum_t ZERO_SUM = '{a: 2'd0, b: 2'd0};

  // control shared by every cell in the row
  typedef struct packed {
    logic load;          // an input item is accepted this cycle
    logic have_pending;  // a row is waiting for the row below it
    logic last;          // the incoming row is the bottom row
  } cell_ctrl_t;

  // one result item
  typedef struct packed {
    logic             last;
    logic [ROW_W-1:0] row;
  } res_t;

  // pushes into the result queue in one cycle
  typedef struct packed {
    logic a;  // result for the pending row
    logic b;  // result for the bottom row
  } push_t;

  // queue status
  typedef struct packed {
    logic [FCNT_W-1:0] count;
    logic              room;  // space for two results
  } fifo_stat_t;

endpackage

// ===== hdl/lgrs_cell.sv =====
// lgrs_cell: one grid column; holds its bits of the two stored rows and
// computes both candidate next-generation bits; depends on lgrs_pkg
`timescale 1ns / 1ps

module lgrs_cell (
  input  logic                clk,
  input  logic                rst,
  input  lgrs_pkg::cell_ctrl_t ctrl,
  input  logic                mask,
  input  logic                row_bit,
  input  lgrs_pkg::col_sum_t  left,
  input  lgrs_pkg::col_sum_t  right,
  output lgrs_pkg::col_sum_t  own,
  output logic                gen_a,
  output logic                gen_b
);

  logic above;
  logic pending;

  logic a_up, a_mid, a_dn;
  logic b_up, b_mid;
  logic [lgrs_pkg::CNT_W-1:0] cnt_a;
  logic [lgrs_pkg::CNT_W-1:0] cnt_b;

  // window rows after width masking
  always_comb begin
    a_up  = above & mask;
    a_mid = pending & mask;
    a_dn  = row_bit & mask;
    b_up  = ctrl.have_pending ? a_mid : a_up;
    b_mid = a_dn;
  end

  // column sums handed to both neighbours
  assign own.a = {1'b0, a_up} + {1'b0, a_mid} + {1'b0, a_dn};
  assign own.b = {1'b0, b_up} + {1'b0, b_mid};

  // 3x3 counts, cell itself included
  assign cnt_a = {2'b00, left.a} + {2'b00, own.a} + {2'b00, right.a};
  assign cnt_b = {2'b00, left.b} + {2'b00, own.b} + {2'b00, right.b};

  // b3/s23 with the centre counted
  assign gen_a = mask & ((cnt_a == lgrs_pkg::BORN_COUNT) ||
                         (a_mid && (cnt_a == lgrs_pkg::KEEP_COUNT)));
  assign gen_b = mask & ((cnt_b == lgrs_pkg::BORN_COUNT) ||
                         (b_mid && (cnt_b == lgrs_pkg::KEEP_COUNT)));

  // stored rows shift down on each accepted item, cleared at the grid bottom
  always_ff @(posedge clk) begin
    if (rst) begin
      above   <= 1'b0;
      pending <= 1'b0;
    end else if (ctrl.load) begin
      if (ctrl.last) begin
        above   <= 1'b0;
        pending <= 1'b0;
      end else begin
        if (ctrl.have_pending) begin
          above <= a_mid;
        end
        pending <= a_dn;
      end
    end
  end

endmodule

// ===== hdl/lgrs_fifo.sv =====
// lgrs_fifo: small result queue taking up to two items a cycle and giving one;
// depends on lgrs_pkg
`timescale 1ns / 1ps

module lgrs_fifo (
  input  logic                 clk,
  input  logic                 rst,
  input  lgrs_pkg::push_t      push,
  input  lgrs_pkg::res_t       data_a,
  input  lgrs_pkg::res_t       data_b,
  output logic                 out_valid,
  input  logic                 out_ready,
  output lgrs_pkg::res_t       out_data,
  output lgrs_pkg::fifo_stat_t stat
);

  lgrs_pkg::res_t mem [lgrs_pkg::FIFO_DEPTH];

  logic [lgrs_pkg::PTR_W-1:0]  wr_ptr;
  logic [lgrs_pkg::PTR_W-1:0]  rd_ptr;
  logic [lgrs_pkg::FCNT_W-1:0] count;
  logic [lgrs_pkg::FCNT_W-1:0] count_next;
  logic [lgrs_pkg::PTR_W-1:0]  wr_ptr_next;
  logic [lgrs_pkg::PTR_W-1:0]  b_ptr;
  logic                        pop;

  assign out_valid  = (count != '0);
  assign pop        = out_valid & out_ready;
  assign out_data   = mem[rd_ptr];
  assign stat.count = count;
  assign stat.room  = (count <= lgrs_pkg::FCNT_W'(lgrs_pkg::FIFO_DEPTH - 2));

  // the bottom-row item goes behind the pending-row item when both arrive
  assign b_ptr = push.a ? wr_ptr + lgrs_pkg::PTR_W'(1) : wr_ptr;

  always_comb begin
    count_next  = count + lgrs_pkg::FCNT_W'(push.a) + lgrs_pkg::FCNT_W'(push.b)
                  - lgrs_pkg::FCNT_W'(pop);
    wr_ptr_next = wr_ptr + lgrs_pkg::PTR_W'(push.a) + lgrs_pkg::PTR_W'(push.b);
  end

  // storage
  always_ff @(posedge clk) begin
    if (push.a) begin
      mem[wr_ptr] <= data_a;
    end
    if (push.b) begin
      mem[b_ptr] <= data_b;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      count  <= count_next;
      if (pop) begin
        rd_ptr <= rd_ptr + lgrs_pkg::PTR_W'(1);
      end
    end
  end

endmodule

// ===== hdl/life_generation_row_stream_top.sv =====
// life_generation_row_stream_top: row-streamed Life (b3/s23) generation step
// built from a row of lgrs_cell columns and an lgrs_fifo result queue; uses lgrs_pkg
//
// Usage:
//   Input channel (in_valid/in_ready) carries one grid row per item, bit c is
//   column c, with last_row marking the bottom row. Output channel
//   (out_valid/out_ready) carries next-generation rows; last_of_grid marks the
//   bottom one. Next row r is computed when row r+1 is accepted; the bottom row
//   also yields its own result in the same cycle, giving two items if a row is pending.
//   Configuration channel (cfg_valid/cfg_ready/cfg_data) writes columns_in_use;
//   columns at or above it read and output as dead. Write only when idle.
// Timing:
//   a result is written to the queue when the item that produces it is accepted.
//   One row is accepted every cycle while in_ready is high; the rate is set by the
//   result queue, which drains one item a cycle while out_ready is high; n rows give n results.
//   in_ready is high while the four-entry queue has room for two results.
// Reset (rst, synchronous): stored rows cleared, queue emptied, width set to 40.
// Stall: when out_ready is low the queue fills and in_ready drops; nothing is lost.
`timescale 1ns / 1ps

module life_generation_row_stream_top (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [lgrs_pkg::ROW_W-1:0] row_cells,
  input  logic                       last_row,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [lgrs_pkg::ROW_W-1:0] next_row,
  output logic                       last_of_grid,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [lgrs_pkg::COL_W-1:0] cfg_data
);

  logic [lgrs_pkg::COL_W-1:0] columns_in_use;
  logic                       have_pending;
  logic [lgrs_pkg::ROW_W-1:0] mask;
  logic [lgrs_pkg::ROW_W-1:0] gen_a;
  logic [lgrs_pkg::ROW_W-1:0] gen_b;
  logic                       load;

  lgrs_pkg::col_sum_t   sums [lgrs_pkg::ROW_W];
  lgrs_pkg::cell_ctrl_t ctrl;
  lgrs_pkg::push_t      push;
  lgrs_pkg::res_t       data_a;
  lgrs_pkg::res_t       data_b;
  lgrs_pkg::res_t       out_data;
  lgrs_pkg::fifo_stat_t stat;

  // configuration register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      columns_in_use <= lgrs_pkg::COLS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      columns_in_use <= cfg_data;
    end
  end

  // column mask, limited to the supported column count
  always_comb begin
    for (int c = 0; c < lgrs_pkg::ROW_W; c++) begin
      mask[c] = (lgrs_pkg::COL_W'(c) < columns_in_use) && (c < lgrs_pkg::MAX_COLUMNS);
    end
  end

  // input handshake and pending-row flag
  assign in_ready = stat.room;
  assign load     = in_valid & in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      have_pending <= 1'b0;
    end else if (load) begin
      have_pending <= ~last_row;
    end
  end

  assign ctrl.load         = load;
  assign ctrl.have_pending = have_pending;
  assign ctrl.last         = last_row;

  // row of column cells, each trading column sums with its neighbours
  for (genvar c = 0; c < lgrs_pkg::ROW_W; c++) begin : g_col
    lgrs_pkg::col_sum_t left;
    lgrs_pkg::col_sum_t right;

    if (c == 0) begin : g_left_edge
      assign left = lgrs_pkg::ZERO_SUM;
    end else begin : g_left
      assign left = sums[c-1];
    end

    if (c == lgrs_pkg::ROW_W - 1) begin : g_right_edge
      assign right = lgrs_pkg::ZERO_SUM;
    end else begin : g_right
      assign right = sums[c+1];
    end

    lgrs_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .ctrl    (ctrl),
      .mask    (mask[c]),
      .row_bit (row_cells[c]),
      .left    (left),
      .right   (right),
      .own     (sums[c]),
      .gen_a   (gen_a[c]),
      .gen_b   (gen_b[c])
    );
  end

  // result queue
  assign push.a      = load & have_pending;
  assign push.b      = load & last_row;
  assign data_a.last = 1'b0;
  assign data_a.row  = gen_a;
  assign data_b.last = 1'b1;
  assign data_b.row  = gen_b;

  lgrs_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .data_a    (data_a),
    .data_b    (data_b),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .stat      (stat)
  );

  assign next_row     = out_data.row;
  assign last_of_grid = out_data.last;

  // checks
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    stat.count <= lgrs_pkg::FCNT_W'(lgrs_pkg::FIFO_DEPTH))
    else $error("result queue overflow");

  a_bottom_clears: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && last_row) |=> !have_pending)
    else $error("pending row survived the bottom row");

  a_row_pending: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && !last_row) |=> have_pending)
    else $error("accepted row not held as pending");

  a_result_shown: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && last_row) |=> out_valid)
    else $error("bottom row gave no result");

endmodule

// ===== tb/sv/tb_life_generation_row_stream_top.sv =====
// tb_life_generation_row_stream_top: self-checking bench for the row-streamed Life generation block
// predicts every next-generation row from the accepted input rows and checks the result stream
// depends on lgrs_pkg and life_generation_row_stream_top
`timescale 1ns / 1ps

module tb_life_generation_row_stream_top;

  localparam int QUIET_LIMIT = 2000;
  localparam int HOLD_CYCLES = 200;
  localparam int SETTLE_CYCLES = 4;

  typedef logic [lgrs_pkg::ROW_W-1:0] row_t;

  typedef struct {
    row_t cells;
    logic last;
  } gen_row_t;

  // running copy of the generation step and the rows still owed by the block
  class next_gen_rows;
    logic [lgrs_pkg::COL_W-1:0] columns;
    row_t                       above;
    row_t                       held;
    logic                       held_valid;
    gen_row_t                   due[$];
    int                         errors;

    function new();
      columns    = lgrs_pkg::COLS_RESET;
      above      = '0;
      held       = '0;
      held_valid = 1'b0;
      errors     = 0;
    endfunction

    function row_t live_mask();
      int w;
      w = columns;
      if (w > lgrs_pkg::MAX_COLUMNS) w = lgrs_pkg::MAX_COLUMNS;
      if (w >= lgrs_pkg::ROW_W) return '1;
      return (row_t'(1) << w) - row_t'(1);
    endfunction

    // b3/s23 with the centre cell counted, dead beyond both edges
    function row_t evolve(row_t up, row_t mid, row_t down);
      row_t                       m;
      row_t                       res;
      logic [lgrs_pkg::ROW_W+1:0] pu, pm, pd;
      int                         count;
      m   = live_mask();
      pu  = {1'b0, up & m, 1'b0};
      pm  = {1'b0, mid & m, 1'b0};
      pd  = {1'b0, down & m, 1'b0};
      res = '0;
      for (int c = 0; c < lgrs_pkg::ROW_W; c++) begin
        count = 0;
        for (int d = 0; d < 3; d++)
          count += int'(pu[c+d]) + int'(pm[c+d]) + int'(pd[c+d]);
        if (pm[c+1])
          res[c] = (count == int'(lgrs_pkg::BORN_COUNT)) ||
                   (count == int'(lgrs_pkg::KEEP_COUNT));
        else
          res[c] = (count == int'(lgrs_pkg::BORN_COUNT));
      end
      return res & m;
    endfunction

    // an input row was accepted
    function void take_row(row_t r, logic last);
      gen_row_t g;
      if (held_valid) begin
        g.cells = evolve(above, held, r);
        g.last  = 1'b0;
        due.insert(due.size(), g);
        above = held & live_mask();
      end
      if (last) begin
        g.cells = evolve(above, r, '0);
        g.last  = 1'b1;
        due.insert(due.size(), g);
        above      = '0;
        held       = '0;
        held_valid = 1'b0;
      end else begin
        held       = r & live_mask();
        held_valid = 1'b1;
      end
    endfunction

    // a result row was accepted
    function void check_row(row_t r, logic last);
      gen_row_t g;
      if (due.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected nothing, actual next_row %h last_of_grid %b",
                 $time, r, last);
        return;
      end
      g = due.pop_front();
      if (r !== g.cells) begin
        errors++;
        $display("%0t: next_row mismatch, expected %h actual %h", $time, g.cells, r);
      end
      if (last !== g.last) begin
        errors++;
        $display("%0t: last_of_grid mismatch, expected %b actual %b", $time, g.last, last);
      end
    endfunction
  endclass

  logic                       clk;
  logic                       rst;
  logic                       in_valid;
  logic                       in_ready;
  row_t                       row_cells;
  logic                       last_row;
  logic                       out_valid;
  logic                       out_ready;
  row_t                       next_row;
  logic                       last_of_grid;
  logic                       cfg_valid;
  logic                       cfg_ready;
  logic [lgrs_pkg::COL_W-1:0] cfg_data;

  next_gen_rows gen_rows = new();
  bit           tx_steady = 1'b0;
  bit           rx_steady = 1'b0;
  bit           hold_request = 1'b0;

  life_generation_row_stream_top u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .row_cells    (row_cells),
    .last_row     (last_row),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .next_row     (next_row),
    .last_of_grid (last_of_grid),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  // clock
  initial clk = 1'b0;
  always #4 clk = ~clk;

  // offer one row, optionally after an idle gap, and wait for it to be taken
  task automatic send_row(row_t r, logic last);
    int gap;
    gap = tx_steady ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid  <= 1'b1;
    row_cells <= r;
    last_row  <= last;
    do @(posedge clk); while (!in_ready);
    gen_rows.take_row(r, last);
  endtask

  // stop offering and let every owed row come out
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (gen_rows.due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_columns(logic [lgrs_pkg::COL_W-1:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    gen_rows.columns = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic row_t random_row();
    row_t a, b, c;
    a = {$urandom, $urandom};
    b = {$urandom, $urandom};
    c = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0, 1:    return a & b & c;
      2:       return a | b;
      3:       return '0;
      4:       return '1;
      5:       return row_t'($urandom_range(0, 7)) << $urandom_range(0, 63);
      6:       return a & b;
      default: return a;
    endcase
  endfunction

  function automatic int grid_height();
    case ($urandom_range(0, 9))
      0:       return 1;
      1:       return $urandom_range(9, 20);
      default: return $urandom_range(2, 8);
    endcase
  endfunction

  // result side: random back-pressure plus one long hold-off on request
  initial begin : drain_results
    int gap;
    out_ready = 1'b0;
    wait (rst === 1'b0);
    forever begin
      if (hold_request) begin
        @(negedge clk);
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_request = 1'b0;
      end
      gap = rx_steady ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
        @(negedge clk);
        out_ready <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      @(negedge clk);
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      gen_rows.check_row(next_row, last_of_grid);
    end
  end

  // give up when no handshake completes for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // stimulus
  initial begin : stimulus
    logic [lgrs_pkg::COL_W-1:0] widths[8];
    int                         rows_left;
    rst       = 1'b1;
    in_valid  = 1'b0;
    row_cells = '0;
    last_row  = 1'b0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    widths    = '{7'd1, 7'd64, 7'd3, 7'd63, 7'd127, 7'd0, 7'd100, 7'd2};
    rows_left = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset width: single-row grid, stripes, blinker at the edge, glider
    send_row('1, 1'b1);
    send_row('1, 1'b0);
    send_row({32{2'b10}}, 1'b0);
    send_row({32{2'b01}}, 1'b0);
    send_row('1, 1'b1);
    send_row('0, 1'b0);
    send_row(row_t'(7) << 38, 1'b0);
    send_row(row_t'(64'h1c), 1'b1);
    send_row(row_t'(2), 1'b0);
    send_row(row_t'(4), 1'b0);
    send_row(row_t'(7), 1'b0);
    send_row('0, 1'b1);

    // full width, corner columns
    settle();
    set_columns(7'd64);
    send_row(row_t'(1) | (row_t'(1) << 63), 1'b0);
    send_row(row_t'(3) | (row_t'(3) << 62), 1'b0);
    send_row('1, 1'b1);

    // no columns in use
    settle();
    set_columns(7'd0);
    send_row('1, 1'b0);
    send_row('1, 1'b1);

    // width above the limit
    settle();
    set_columns(7'd127);
    send_row(random_row(), 1'b0);
    send_row('1, 1'b1);

    // width changed while a grid is half way through
    settle();
    set_columns(7'd3);
    send_row(row_t'(7), 1'b0);
    settle();
    set_columns(7'd1);
    send_row(row_t'(7), 1'b0);
    send_row(row_t'(7), 1'b1);

    // random grids; a phase may end mid-grid so the next width lands inside it
    for (int p = 0; p < 8; p++) begin
      settle();
      set_columns(p == 7 ? 7'($urandom_range(1, 64)) : widths[p]);
      tx_steady = (p == 1) || (p == 5);
      rx_steady = (p == 2) || (p == 5);
      if (p == 3) hold_request = 1'b1;
      for (int n = 0; n < 90; n++) begin
        if (rows_left == 0) rows_left = grid_height();
        rows_left--;
        send_row(random_row(), rows_left == 0);
      end
    end
    if (rows_left != 0) send_row(random_row(), 1'b1);

    // drain and report
    settle();
    repeat (8) @(posedge clk);
    if (gen_rows.errors == 0 && gen_rows.due.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
